// File: hw/rtl/vdg_pkg.sv
// Shared types, constants and colour helpers for the VDG pixel word generator.
// No dependencies; used by vdg_pixel_word_generator.
package vdg_pkg;

	localparam int unsigned MODE_W   = 8;
	localparam int unsigned PHASE_W  = 2;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned ROW_W    = 4;
	localparam int unsigned NIB_W    = 4;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned PIX_WORD = WORD_W / NIB_W;
	localparam int unsigned PIX_ALL  = 2 * PIX_WORD;
	localparam int unsigned CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VDG_MODE       = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ARTIFACT_PHASE = 1'd1;

	// artifact phase codes
	localparam logic [PHASE_W-1:0] ART_OFF    = 2'd0;
	localparam logic [PHASE_W-1:0] ART_PHASE1 = 2'd1;
	localparam logic [PHASE_W-1:0] ART_PHASE2 = 2'd2;

	// graphics mode field values (vdg_mode[7:4])
	localparam logic [3:0] GM_CG1   = 4'd8;
	localparam logic [3:0] GM_RG1_A = 4'd9;
	localparam logic [3:0] GM_RG1_B = 4'd11;
	localparam logic [3:0] GM_RG1_C = 4'd13;
	localparam logic [3:0] GM_RG6   = 4'd15;

	// fixed colours
	localparam logic [NIB_W-1:0] COL_BLACK   = 4'd8;
	localparam logic [NIB_W-1:0] COL_TXT_FG0 = 4'd0;
	localparam logic [NIB_W-1:0] COL_TXT_FG1 = 4'd7;
	localparam logic [NIB_W-1:0] COL_TXT_BG0 = 4'd12;
	localparam logic [NIB_W-1:0] COL_TXT_BG1 = 4'd13;

	// semigraphic row splits
	localparam logic [ROW_W-1:0] SG4_SPLIT  = 4'd6;
	localparam logic [ROW_W-1:0] SG6_SPLIT1 = 4'd4;
	localparam logic [ROW_W-1:0] SG6_SPLIT2 = 4'd8;

	typedef enum logic [2:0] {
		KIND_TEXT    = 3'd0,
		KIND_CG1     = 3'd1,
		KIND_RG1     = 3'd2,
		KIND_CG2     = 3'd3,
		KIND_RG6     = 3'd4,
		KIND_RG6_ART = 3'd5
	} kind_t;

	// decoded mode, carried alongside each transaction
	typedef struct packed {
		kind_t kind;
		logic  css;
		logic  sg6;
		logic  art_alt;   // second artifact ordering
	} mode_dec_t;

	typedef logic [PIX_ALL-1:0][1:0]  code_vec_t;
	typedef logic [3:0][NIB_W-1:0]    cmap_t;

	// artifact colour for a 2-bit pair; alt swaps the middle two entries
	function automatic logic [NIB_W-1:0] art_colour(input logic alt, input logic [1:0] idx);
		logic [1:0] j;
		begin
			j = idx;
			if (alt && (idx[1] != idx[0])) begin
				j = {idx[0], idx[1]};
			end
			return {2'b10, j};
		end
	endfunction

	// four-colour ramp offset by colour set
	function automatic logic [NIB_W-1:0] set_colour(input logic css, input logic [1:0] idx);
		begin
			return {1'b0, css, idx};
		end
	endfunction

endpackage

// File: hw/rtl/vdg_pixel_word_generator.sv
// VDG pixel word generator: one video byte in, one or two 32-bit pixel words out.
// Depends on vdg_pkg.
//
// Usage
//  Configuration: write vdg_mode (index 0) and artifact_phase (index 1) on the
//  cfg channel; cfg_ready is always high, so a write completes whenever
//  cfg_valid is high. Write only while no transaction is in flight.
//  Input: a transaction (data_byte, text_row, font_bits) is accepted at each
//  rising edge with start high and busy low. busy is held low: the pipeline
//  never backs up, so a transaction may be offered on every cycle.
//  Output: done strobes for one cycle with first_word, second_word and
//  two_words. The receiver cannot stall; results are simply presented.
//  Ordering: an accepted transaction is registered in s1, then s2, then s3,
//  which presents it. Throughput: one transaction per cycle.
//  Pipeline: s1 registers the inputs and the decoded mode; s2 holds a 2-bit
//  colour code per pixel plus a four-entry colour map; s3 resolves the map
//  into the output words.
//  Reset: arst_n clears the mode registers to zero (text, colour set 0, no
//  artifact colours) and empties the pipeline at once.
module vdg_pixel_word_generator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [vdg_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [vdg_pkg::MODE_W-1:0]            cfg_data,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [vdg_pkg::BYTE_W-1:0]            data_byte,
	input  logic [vdg_pkg::ROW_W-1:0]             text_row,
	input  logic [vdg_pkg::BYTE_W-1:0]            font_bits,
	output logic                                  done,
	output logic [vdg_pkg::WORD_W-1:0]            first_word,
	output logic [vdg_pkg::WORD_W-1:0]            second_word,
	output logic                                  two_words
);

	// configuration registers
	logic [vdg_pkg::MODE_W-1:0]  vdg_mode_q;
	logic [vdg_pkg::PHASE_W-1:0] artifact_phase_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vdg_mode_q       <= '0;
			artifact_phase_q <= vdg_pkg::ART_OFF;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vdg_pkg::REG_VDG_MODE:       vdg_mode_q <= cfg_data;
				vdg_pkg::REG_ARTIFACT_PHASE: artifact_phase_q <= cfg_data[vdg_pkg::PHASE_W-1:0];
				default: ;
			endcase
		end
	end

	// mode decode (the user keeps the registers static while transactions flow; the block does not enforce it)
	vdg_pkg::mode_dec_t mode_dec;
	logic [3:0]         gm;
	logic               art_on;

	assign gm     = vdg_mode_q[7:4];
	assign art_on = (artifact_phase_q == vdg_pkg::ART_PHASE1)
	             || (artifact_phase_q == vdg_pkg::ART_PHASE2);

	always_comb begin
		mode_dec.css     = vdg_mode_q[3];
		mode_dec.sg6     = vdg_mode_q[4];
		mode_dec.art_alt = (artifact_phase_q == vdg_pkg::ART_PHASE2);
		if (!gm[3]) begin
			mode_dec.kind = vdg_pkg::KIND_TEXT;
		end else begin
			unique case (gm) inside
				vdg_pkg::GM_CG1: mode_dec.kind = vdg_pkg::KIND_CG1;
				vdg_pkg::GM_RG1_A, vdg_pkg::GM_RG1_B, vdg_pkg::GM_RG1_C:
					mode_dec.kind = vdg_pkg::KIND_RG1;
				vdg_pkg::GM_RG6: mode_dec.kind = (vdg_mode_q[3] && art_on)
				                                 ? vdg_pkg::KIND_RG6_ART : vdg_pkg::KIND_RG6;
				default:         mode_dec.kind = vdg_pkg::KIND_CG2;
			endcase
		end
	end

	// ---------------- stage 1: inputs and decoded mode
	logic                        valid_s1;
	logic [vdg_pkg::BYTE_W-1:0]  byte_s1;
	logic [vdg_pkg::ROW_W-1:0]   row_s1;
	logic [vdg_pkg::BYTE_W-1:0]  font_s1;
	vdg_pkg::mode_dec_t          mode_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			byte_s1 <= data_byte;
			row_s1  <= text_row;
			font_s1 <= font_bits;
			mode_s1 <= mode_dec;
		end
	end

	// ---------------- stage 2: per-pixel colour codes and colour map
	vdg_pkg::code_vec_t code_c;
	vdg_pkg::cmap_t     cmap_c;
	logic               two_c;
	logic [vdg_pkg::BYTE_W-1:0] pat;
	logic               blk_l, blk_r;
	logic [3:0]         hi_n, lo_n;

	always_comb begin
		code_c = '0;
		cmap_c = '0;
		two_c  = 1'b0;
		pat    = '0;
		blk_l  = 1'b0;
		blk_r  = 1'b0;
		hi_n   = byte_s1[7:4];
		lo_n   = byte_s1[3:0];
		case (mode_s1.kind)
			vdg_pkg::KIND_TEXT: begin
				if (!byte_s1[7]) begin
					// alphanumeric, or SG6 low codes using the byte as pattern
					pat = mode_s1.sg6 ? byte_s1 : font_s1;
					if (byte_s1[6]) begin
						pat = ~pat;
					end
					cmap_c[0] = mode_s1.css ? vdg_pkg::COL_TXT_BG1 : vdg_pkg::COL_TXT_BG0;
					cmap_c[1] = mode_s1.css ? vdg_pkg::COL_TXT_FG1 : vdg_pkg::COL_TXT_FG0;
					for (int k = 0; k < vdg_pkg::PIX_WORD; k++) begin
						code_c[k] = {1'b0, pat[vdg_pkg::PIX_WORD-1-k]};
					end
				end else begin
					if (!mode_s1.sg6) begin
						if (row_s1 < vdg_pkg::SG4_SPLIT) begin
							blk_l = byte_s1[3];
							blk_r = byte_s1[2];
						end else begin
							blk_l = byte_s1[1];
							blk_r = byte_s1[0];
						end
					end else begin
						if (row_s1 < vdg_pkg::SG6_SPLIT1) begin
							blk_l = byte_s1[5];
							blk_r = byte_s1[4];
						end else if (row_s1 < vdg_pkg::SG6_SPLIT2) begin
							blk_l = byte_s1[3];
							blk_r = byte_s1[2];
						end else begin
							blk_l = byte_s1[1];
							blk_r = byte_s1[0];
						end
					end
					cmap_c[0] = vdg_pkg::COL_BLACK;
					cmap_c[1] = {1'b0, byte_s1[6:4]};
					for (int k = 0; k < vdg_pkg::PIX_WORD; k++) begin
						code_c[k] = {1'b0, (k < vdg_pkg::PIX_WORD / 2) ? blk_l : blk_r};
					end
				end
			end
			vdg_pkg::KIND_CG1: begin
				two_c = 1'b1;
				for (int i = 0; i < 4; i++) begin
					cmap_c[i] = vdg_pkg::set_colour(mode_s1.css, 2'(i));
				end
				for (int k = 0; k < vdg_pkg::PIX_WORD; k++) begin
					code_c[k]                    = (k < vdg_pkg::PIX_WORD / 2) ? hi_n[3:2] : hi_n[1:0];
					code_c[k + vdg_pkg::PIX_WORD] = (k < vdg_pkg::PIX_WORD / 2) ? lo_n[3:2] : lo_n[1:0];
				end
			end
			vdg_pkg::KIND_RG1: begin
				two_c     = 1'b1;
				cmap_c[0] = vdg_pkg::COL_BLACK;
				cmap_c[1] = {1'b0, mode_s1.css, 2'b00};
				for (int k = 0; k < vdg_pkg::PIX_WORD; k++) begin
					code_c[k]                    = {1'b0, hi_n[3 - k / 2]};
					code_c[k + vdg_pkg::PIX_WORD] = {1'b0, lo_n[3 - k / 2]};
				end
			end
			vdg_pkg::KIND_RG6: begin
				cmap_c[0] = vdg_pkg::COL_BLACK;
				cmap_c[1] = {1'b0, mode_s1.css, 2'b00};
				for (int k = 0; k < vdg_pkg::PIX_WORD; k++) begin
					code_c[k] = {1'b0, byte_s1[vdg_pkg::PIX_WORD-1-k]};
				end
			end
			vdg_pkg::KIND_RG6_ART: begin
				for (int i = 0; i < 4; i++) begin
					cmap_c[i] = vdg_pkg::art_colour(mode_s1.art_alt, 2'(i));
				end
				for (int k = 0; k < vdg_pkg::PIX_WORD; k++) begin
					code_c[k] = byte_s1[7 - 2 * (k / 2) -: 2];
				end
			end
			default: begin
				// CG2
				for (int i = 0; i < 4; i++) begin
					cmap_c[i] = vdg_pkg::set_colour(mode_s1.css, 2'(i));
				end
				for (int k = 0; k < vdg_pkg::PIX_WORD; k++) begin
					code_c[k] = byte_s1[7 - 2 * (k / 2) -: 2];
				end
			end
		endcase
	end

	logic               valid_s2;
	vdg_pkg::code_vec_t code_s2;
	vdg_pkg::cmap_t     cmap_s2;
	logic               two_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			code_s2 <= code_c;
			cmap_s2 <= cmap_c;
			two_s2  <= two_c;
		end
	end

	// ---------------- stage 3: resolve colour map into words
	logic [vdg_pkg::WORD_W-1:0] w0_c, w1_c;

	always_comb begin
		for (int k = 0; k < vdg_pkg::PIX_WORD; k++) begin
			w0_c[k*vdg_pkg::NIB_W +: vdg_pkg::NIB_W] = cmap_s2[code_s2[k]];
			w1_c[k*vdg_pkg::NIB_W +: vdg_pkg::NIB_W] = two_s2
				? cmap_s2[code_s2[k + vdg_pkg::PIX_WORD]] : '0;
		end
	end

	logic                       valid_s3;
	logic [vdg_pkg::WORD_W-1:0] w0_s3, w1_s3;
	logic                       two_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			w0_s3  <= w0_c;
			w1_s3  <= w1_c;
			two_s3 <= two_s2;
		end
	end

	assign done        = valid_s3;
	assign first_word  = w0_s3;
	assign second_word = w1_s3;
	assign two_words   = two_s3;

	// ---------------- assertions
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("accepted transaction not presented after three cycles");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without a matching transaction");

	a_second_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !two_words) |-> (second_word == '0))
		else $error("second word not zero in single-word mode");

	a_two_follows_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && two_s2) |-> (mode_s1.kind == vdg_pkg::KIND_CG1
		                         || mode_s1.kind == vdg_pkg::KIND_RG1
		                         || !valid_s1))
		else $error("two-word flag inconsistent with decoded mode");

endmodule

// File: dv/tb_vdg_pixel_word_generator.sv
// Self-checking testbench for vdg_pixel_word_generator: predicts the pixel words
// for each accepted transaction and checks every result. Depends on vdg_pkg.
module tb_vdg_pixel_word_generator;

	// Top of the alphanumeric / semigraphic mode range (0..7)
	localparam logic [3:0] GM_TEXT_LAST = 4'd7;
	// Spare phase code, behaves as no artifact colours
	localparam logic [vdg_pkg::PHASE_W-1:0] ART_SPARE = 2'd3;

	// Artifact colour orderings, entry i for pair code i
	localparam vdg_pkg::cmap_t ART_ORDER1 = {4'd11, 4'd10, 4'd9, 4'd8};
	localparam vdg_pkg::cmap_t ART_ORDER2 = {4'd11, 4'd9, 4'd10, 4'd8};

	localparam int unsigned DRAIN_CYCLES      = 6;    // pipeline is three deep
	localparam int unsigned ITEMS_PER_SETTING = 25;
	localparam int unsigned ITEMS_PER_PHASE   = 100;

	typedef struct packed {
		logic [vdg_pkg::WORD_W-1:0] first_word;
		logic [vdg_pkg::WORD_W-1:0] second_word;
		logic                       two_words;
	} pix_words_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [vdg_pkg::CFG_IDX_W-1:0] cfg_index = vdg_pkg::REG_VDG_MODE;
	logic [vdg_pkg::MODE_W-1:0]    cfg_data = '0;
	logic                          start = 1'b0;
	logic                          busy;
	logic [vdg_pkg::BYTE_W-1:0]    data_byte = '0;
	logic [vdg_pkg::ROW_W-1:0]     text_row = '0;
	logic [vdg_pkg::BYTE_W-1:0]    font_bits = '0;
	logic                          done;
	logic [vdg_pkg::WORD_W-1:0]    first_word;
	logic [vdg_pkg::WORD_W-1:0]    second_word;
	logic                          two_words;

	// Testbench copy of the mode registers, updated on each accepted write
	logic [vdg_pkg::MODE_W-1:0]  cur_mode = '0;
	logic [vdg_pkg::PHASE_W-1:0] cur_phase = vdg_pkg::ART_OFF;

	pix_words_t  pending_words[$];   // predicted words, oldest first
	int unsigned mismatch_count = 0;
	int unsigned sender_idle_pct = 0;

	vdg_pixel_word_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.start       (start),
		.busy        (busy),
		.data_byte   (data_byte),
		.text_row    (text_row),
		.font_bits   (font_bits),
		.done        (done),
		.first_word  (first_word),
		.second_word (second_word),
		.two_words   (two_words)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------------

	// Eight pixels from a bit pattern, MSB is the leftmost pixel (lowest nibble)
	function automatic logic [vdg_pkg::WORD_W-1:0] spread_bits(input logic [7:0] pat,
			input logic [vdg_pkg::NIB_W-1:0] on_col, input logic [vdg_pkg::NIB_W-1:0] off_col);
		logic [vdg_pkg::WORD_W-1:0] w;
		w = '0;
		for (int k = 0; k < 8; k++) begin
			w[4*k +: 4] = pat[7-k] ? on_col : off_col;
		end
		return w;
	endfunction

	// Semigraphic block row: left four pixels, right four pixels, black when off
	function automatic logic [vdg_pkg::WORD_W-1:0] block_row(input logic left_on,
			input logic right_on, input logic [vdg_pkg::NIB_W-1:0] fg);
		logic [vdg_pkg::WORD_W-1:0] w;
		w = '0;
		for (int k = 0; k < 8; k++) begin
			w[4*k +: 4] = ((k < 4) ? left_on : right_on) ? fg : vdg_pkg::COL_BLACK;
		end
		return w;
	endfunction

	// Four 2-bit codes, first code from the top bits, each giving two pixels
	function automatic logic [vdg_pkg::WORD_W-1:0] double_pairs(input logic [7:0] c,
			input vdg_pkg::cmap_t cmap);
		logic [vdg_pkg::WORD_W-1:0] w;
		logic [vdg_pkg::NIB_W-1:0]  col;
		w = '0;
		for (int k = 0; k < 4; k++) begin
			col = cmap[c[7-2*k -: 2]];
			w[8*k +: 8] = {col, col};
		end
		return w;
	endfunction

	function automatic pix_words_t predict_pixel_words(input logic [vdg_pkg::MODE_W-1:0] mode,
			input logic [vdg_pkg::PHASE_W-1:0] phase, input logic [vdg_pkg::BYTE_W-1:0] c,
			input logic [vdg_pkg::ROW_W-1:0] row, input logic [vdg_pkg::BYTE_W-1:0] font);
		logic [3:0]                gm;
		logic                      css;
		logic                      sg6;
		logic [vdg_pkg::NIB_W-1:0] fg;
		logic [vdg_pkg::NIB_W-1:0] bg;
		logic [vdg_pkg::NIB_W-1:0] col;
		logic [vdg_pkg::NIB_W-1:0] rg_on;
		logic [vdg_pkg::NIB_W-1:0] a;
		logic [vdg_pkg::NIB_W-1:0] b;
		logic [7:0]                pat;
		vdg_pkg::cmap_t            cmap;
		pix_words_t                r;
		gm    = mode[7:4];
		css   = mode[3];
		sg6   = mode[4];
		rg_on = {1'b0, css, 2'b00};
		r     = '0;
		if (gm <= GM_TEXT_LAST) begin
			fg = css ? vdg_pkg::COL_TXT_FG1 : vdg_pkg::COL_TXT_FG0;
			bg = css ? vdg_pkg::COL_TXT_BG1 : vdg_pkg::COL_TXT_BG0;
			if (!c[7]) begin
				// alphanumeric; in SG6 the byte itself is the pattern
				pat = sg6 ? c : font;
				if (c[6]) begin
					pat = ~pat;
				end
				r.first_word = spread_bits(pat, fg, bg);
			end else begin
				col = {1'b0, c[6:4]};
				// rows past the cell fall into the last block row
				if (!sg6) begin
					r.first_word = (row < vdg_pkg::SG4_SPLIT) ? block_row(c[3], c[2], col)
					                                          : block_row(c[1], c[0], col);
				end else if (row < vdg_pkg::SG6_SPLIT1) begin
					r.first_word = block_row(c[5], c[4], col);
				end else if (row < vdg_pkg::SG6_SPLIT2) begin
					r.first_word = block_row(c[3], c[2], col);
				end else begin
					r.first_word = block_row(c[1], c[0], col);
				end
			end
		end else if (gm == vdg_pkg::GM_CG1) begin
			// high nibble then low nibble, two colour groups of four pixels each
			for (int k = 0; k < 8; k++) begin
				r.first_word[4*k +: 4]  = {1'b0, css, (k < 4) ? c[7:6] : c[5:4]};
				r.second_word[4*k +: 4] = {1'b0, css, (k < 4) ? c[3:2] : c[1:0]};
			end
			r.two_words = 1'b1;
		end else if (gm == vdg_pkg::GM_RG1_A || gm == vdg_pkg::GM_RG1_B
		             || gm == vdg_pkg::GM_RG1_C) begin
			for (int k = 0; k < 4; k++) begin
				a = c[7-k] ? rg_on : vdg_pkg::COL_BLACK;
				b = c[3-k] ? rg_on : vdg_pkg::COL_BLACK;
				r.first_word[8*k +: 8]  = {a, a};
				r.second_word[8*k +: 8] = {b, b};
			end
			r.two_words = 1'b1;
		end else if (gm == vdg_pkg::GM_RG6) begin
			if (css && (phase == vdg_pkg::ART_PHASE1 || phase == vdg_pkg::ART_PHASE2)) begin
				cmap = (phase == vdg_pkg::ART_PHASE1) ? ART_ORDER1 : ART_ORDER2;
				r.first_word = double_pairs(c, cmap);
			end else begin
				r.first_word = spread_bits(c, rg_on, vdg_pkg::COL_BLACK);
			end
		end else begin
			// CG2
			for (int i = 0; i < 4; i++) begin
				cmap[i] = {1'b0, css, 2'(i)};
			end
			r.first_word = double_pairs(c, cmap);
		end
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------------

	task automatic flag_mismatch(input string what, input logic [vdg_pkg::WORD_W-1:0] got,
			input logic [vdg_pkg::WORD_W-1:0] want);
		$display("%0t  %s: got %h, predicted %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Results are sampled at the edge that ends their cycle; accepted transactions
	// are predicted at the same edge from the values held before it.
	always @(posedge clk) begin
		pix_words_t want;
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				flag_mismatch("result with nothing pending, first_word", first_word, '0);
			end else begin
				want = pending_words.pop_front();
				if (first_word !== want.first_word)
					flag_mismatch("first_word", first_word, want.first_word);
				if (second_word !== want.second_word)
					flag_mismatch("second_word", second_word, want.second_word);
				if (two_words !== want.two_words)
					flag_mismatch("two_words", 32'(two_words), 32'(want.two_words));
			end
		end
		if (arst_n && start && !busy) begin
			pending_words.push_back(predict_pixel_words(cur_mode, cur_phase,
				data_byte, text_row, font_bits));
		end
	end

	// ---------------------------------------------------------------------
	// Drivers; every task returns just after a rising edge
	// ---------------------------------------------------------------------

	// Offer one transaction, hold it until taken, then idle at random.
	// busy is looked at on the falling edge so the accepting edge is race free.
	task automatic send_item(input logic [vdg_pkg::BYTE_W-1:0] c,
			input logic [vdg_pkg::ROW_W-1:0] row, input logic [vdg_pkg::BYTE_W-1:0] font);
		logic        stalled;
		int unsigned gap;
		start     <= 1'b1;
		data_byte <= c;
		text_row  <= row;
		font_bits <= font;
		do begin
			@(negedge clk);
			stalled = busy;
			@(posedge clk);
		end while (stalled);
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap != 0) begin
			start     <= 1'b0;
			data_byte <= 8'($urandom_range(255));   // junk while idle
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every predicted result has been seen
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	// One register write; cfg_valid is left high for a following write
	task automatic write_reg(input logic [vdg_pkg::CFG_IDX_W-1:0] idx,
			input logic [vdg_pkg::MODE_W-1:0] value);
		logic stalled;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do begin
			@(negedge clk);
			stalled = !cfg_ready;
			@(posedge clk);
		end while (stalled);
		if (idx == vdg_pkg::REG_VDG_MODE)
			cur_mode = value;
		else
			cur_phase = value[vdg_pkg::PHASE_W-1:0];   // upper data bits are ignored
	endtask

	// Both registers, only once the block is idle
	task automatic configure(input logic [vdg_pkg::MODE_W-1:0] mode,
			input logic [vdg_pkg::MODE_W-1:0] phase_data);
		wait_drained();
		write_reg(vdg_pkg::REG_VDG_MODE, mode);
		write_reg(vdg_pkg::REG_ARTIFACT_PHASE, phase_data);
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Reset mode (SG4, colour set 0) first, then SG6 with colour set 1
	task automatic test_text_modes();
		send_item(8'h00, 4'd0, 8'h00);
		send_item(8'h3F, 4'd11, 8'hFF);
		send_item(8'h40, 4'd3, 8'h0F);     // inverse video
		send_item(8'h8A, 4'd5, 8'h00);     // top half
		send_item(8'h85, 4'd6, 8'hFF);     // bottom half
		send_item(8'hF5, 4'd15, 8'hA5);    // row beyond the cell
		configure(8'h18, {6'd0, vdg_pkg::ART_OFF});
		send_item(8'h7F, 4'd0, 8'h00);     // byte is the pattern, inverted
		send_item(8'h25, 4'd2, 8'hFF);
		send_item(8'hB0, 4'd3, 8'h00);     // top third
		send_item(8'h8C, 4'd4, 8'h00);     // middle third
		send_item(8'h83, 4'd11, 8'h00);    // bottom third
		send_item(8'hFF, 4'd12, 8'h00);    // row beyond the cell
	endtask

	// CG1 and the three RG1 encodings, both colour sets
	task automatic test_two_word_modes();
		configure(8'h80, {6'd0, vdg_pkg::ART_OFF});
		send_item(8'h1B, 4'd0, 8'h00);
		configure(8'h88, {6'd0, vdg_pkg::ART_OFF});
		send_item(8'hE4, 4'd0, 8'h00);
		configure(8'h98, {6'd0, vdg_pkg::ART_OFF});
		send_item(8'hA5, 4'd0, 8'h00);
		configure(8'hB0, {6'd0, vdg_pkg::ART_OFF});
		send_item(8'h5A, 4'd0, 8'h00);
		configure(8'hD8, {6'd0, vdg_pkg::ART_OFF});
		send_item(8'hFF, 4'd0, 8'h00);
	endtask

	// CG2 variants, RG6 across every artifact phase including the spare code
	task automatic test_graphics_modes();
		configure(8'hA0, {6'd0, vdg_pkg::ART_OFF});
		send_item(8'hE4, 4'd0, 8'h00);
		configure(8'hC8, {6'd0, vdg_pkg::ART_OFF});
		send_item(8'h1B, 4'd0, 8'h00);
		configure(8'hE0, {6'd0, vdg_pkg::ART_OFF});
		send_item(8'h00, 4'd0, 8'h00);
		configure(8'hF8, {6'd0, vdg_pkg::ART_OFF});
		send_item(8'hE4, 4'd0, 8'h00);
		configure(8'hF8, {6'd0, vdg_pkg::ART_PHASE1});
		send_item(8'hE4, 4'd0, 8'h00);
		configure(8'hF8, {6'd0, vdg_pkg::ART_PHASE2});
		send_item(8'hE4, 4'd0, 8'h00);
		configure(8'hFF, {6'h3F, ART_SPARE});
		send_item(8'hE4, 4'd0, 8'h00);
		configure(8'hF0, {6'd0, vdg_pkg::ART_PHASE1});  // colour set 0: no artifacts
		send_item(8'hE4, 4'd0, 8'h00);
		configure(8'h00, 8'h00);
		send_item(8'h55, 4'd7, 8'hAA);
	endtask

	// Random transactions, a fresh mode setting every 25 of them
	task automatic test_random_traffic(input int unsigned idle_pct);
		logic [vdg_pkg::MODE_W-1:0] mode;
		sender_idle_pct = idle_pct;
		for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
			if (i % ITEMS_PER_SETTING == 0) begin
				case ($urandom_range(5))
					0: mode = 8'h00;
					1: mode = 8'hFF;
					2: mode = {vdg_pkg::GM_RG6, 1'b1, 3'($urandom_range(7))};
					default: mode = 8'($urandom_range(255));
				endcase
				configure(mode, 8'($urandom_range(255)));
			end
			send_item(8'($urandom_range(255)), 4'($urandom_range(15)),
				8'($urandom_range(255)));
		end
		sender_idle_pct = 0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_text_modes();
		test_two_word_modes();
		test_graphics_modes();

		// receiver cannot stall, so its phases reduce to sender idling only
		test_random_traffic(0);
		test_random_traffic(62);
		test_random_traffic(0);
		test_random_traffic(33);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);   // catch any stray result
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run
	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
